// ----- rtl/hdr_gainmap_metadata_parser_core_macros.svh -----
// Assertion macros used by the gain-map metadata parser RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef HDR_GAINMAP_METADATA_PARSER_CORE_MACROS_SVH
`define HDR_GAINMAP_METADATA_PARSER_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define HGMP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that, when seen, requires a consequence at the next clock edge.
`define HGMP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/hgmp_pkg.sv -----
// Types and constants for the gain-map metadata parser.
// Used by hgmp_parser, hgmp_out_queue and the top level; no dependencies.
package hgmp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEADER      = 4'd0,
    PH_TOTAL_HI    = 4'd1,
    PH_TOTAL_LO    = 4'd2,
    PH_STATIC_HI   = 4'd3,
    PH_STATIC_LO   = 4'd4,
    PH_STATIC_DATA = 4'd5,
    PH_DYN_HI      = 4'd6,
    PH_DYN_LO      = 4'd7,
    PH_DYN_PREFIX  = 4'd8,
    PH_DYN_DATA    = 4'd9
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_STATIC  = 2'd0;
  localparam logic [1:0] KIND_DYNAMIC = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TAG       = 3'd1;
  localparam logic [2:0] ST_FRAMES    = 3'd2;
  localparam logic [2:0] ST_FILETYPE  = 3'd3;
  localparam logic [2:0] ST_NO_META   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  // Header layout and limits
  localparam logic [15:0] TAG_BYTES      = 16'd6;
  localparam logic [15:0] POS_FRAMES     = 16'd9;
  localparam logic [15:0] POS_FILETYPE   = 16'd10;
  localparam logic [15:0] POS_METATYPE   = 16'd11;
  localparam logic [15:0] POS_HEADER_END = 16'd13;
  localparam logic [15:0] MIN_LENGTH     = 16'd16;
  localparam logic [15:0] POS_SATURATED  = 16'hFFFF;
  localparam logic [7:0]  MIN_FRAME_COUNT = 8'd2;
  localparam logic [7:0]  FILE_TYPE_GAINMAP = 8'd2;
  localparam logic [15:0] DYN_PREFIX_SIZE   = 16'd5;

  // One result item
  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last_result;
  } result_t;

  // Results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Expected tag "ITUT35"
  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h49;
      3'd1:    b = 8'h54;
      3'd2:    b = 8'h55;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h33;
      3'd5:    b = 8'h35;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/hgmp_parser.sv -----
// Byte-level parser state and per-byte decision logic.
// Depends on hgmp_pkg; produces up to two results per transfer.
module hgmp_parser
  import hgmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  data_byte,
  input  logic [15:0] payload_length,
  input  logic        end_of_marker,
  output push_t       push
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  size_hi_r, size_hi_nxt;
  logic        verdict_sent_r, verdict_sent_nxt;

  logic [15:0] len_eff;
  logic [15:0] room;
  logic [15:0] size;
  logic [15:0] rem_dec;
  logic [7:0]  pre_dec;
  logic        data_v;
  logic [1:0]  data_kind;
  logic        verd_v;
  logic [2:0]  verd_st;
  result_t     data_res, verd_res;

  assign len_eff = (pos_r == 16'd0) ? payload_length : len_r;
  assign room    = len_eff - pos_r - 16'd1;
  assign size    = {size_hi_r, data_byte};
  assign rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;
  assign pre_dec = (size_hi_r != 8'd0) ? size_hi_r - 8'd1 : 8'd0;

  // Decide the next state and the results of this byte
  always_comb begin
    phase_nxt        = phase_r;
    pos_nxt          = (pos_r != POS_SATURATED) ? pos_r + 16'd1 : pos_r;
    len_nxt          = len_eff;
    rem_nxt          = rem_r;
    size_hi_nxt      = size_hi_r;
    data_v           = 1'b0;
    data_kind        = KIND_STATIC;
    verd_v           = 1'b0;
    verd_st          = ST_OK;
    if (!verdict_sent_r) begin
      if (pos_r >= len_eff) begin
        verd_v  = 1'b1;
        verd_st = ST_TRUNCATED;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (pos_r < TAG_BYTES) begin
              if (data_byte != tag_byte(pos_r[2:0])) begin
                verd_v  = 1'b1;
                verd_st = ST_TAG;
              end
            end else if (pos_r == POS_FRAMES) begin
              if (data_byte < MIN_FRAME_COUNT) begin
                verd_v  = 1'b1;
                verd_st = ST_FRAMES;
              end
            end else if (pos_r == POS_FILETYPE) begin
              if (data_byte != FILE_TYPE_GAINMAP) begin
                verd_v  = 1'b1;
                verd_st = ST_FILETYPE;
              end
            end else if (pos_r == POS_METATYPE) begin
              if (data_byte == 8'd0 || len_eff <= MIN_LENGTH) begin
                verd_v  = 1'b1;
                verd_st = ST_NO_META;
              end
            end
            if (pos_r >= POS_HEADER_END) phase_nxt = PH_TOTAL_HI;
          end
          PH_TOTAL_HI: begin
            size_hi_nxt = data_byte;
            phase_nxt   = PH_TOTAL_LO;
          end
          PH_STATIC_HI: begin
            size_hi_nxt = data_byte;
            phase_nxt   = PH_STATIC_LO;
          end
          PH_DYN_HI: begin
            size_hi_nxt = data_byte;
            phase_nxt   = PH_DYN_LO;
          end
          PH_TOTAL_LO: begin
            if (size > room) begin
              verd_v  = 1'b1;
              verd_st = ST_OVERFLOW;
            end else begin
              phase_nxt = PH_STATIC_HI;
            end
          end
          PH_STATIC_LO: begin
            if (size > room) begin
              verd_v  = 1'b1;
              verd_st = ST_OVERFLOW;
            end else if (size != 16'd0) begin
              rem_nxt   = size;
              phase_nxt = PH_STATIC_DATA;
            end else begin
              phase_nxt = PH_DYN_HI;
            end
          end
          PH_STATIC_DATA: begin
            data_v    = 1'b1;
            data_kind = KIND_STATIC;
            rem_nxt   = rem_dec;
            if (rem_dec == 16'd0) phase_nxt = PH_DYN_HI;
          end
          PH_DYN_LO: begin
            if (size == 16'd0) begin
              verd_v  = 1'b1;
              verd_st = ST_OK;
            end else if (size > room || size < DYN_PREFIX_SIZE) begin
              verd_v  = 1'b1;
              verd_st = ST_OVERFLOW;
            end else begin
              rem_nxt     = size - DYN_PREFIX_SIZE;
              size_hi_nxt = DYN_PREFIX_SIZE[7:0];
              phase_nxt   = PH_DYN_PREFIX;
            end
          end
          PH_DYN_PREFIX: begin
            size_hi_nxt = pre_dec;
            if (pre_dec == 8'd0) begin
              if (rem_r == 16'd0) begin
                verd_v  = 1'b1;
                verd_st = ST_OK;
              end else begin
                phase_nxt = PH_DYN_DATA;
              end
            end
          end
          PH_DYN_DATA: begin
            data_v    = 1'b1;
            data_kind = KIND_DYNAMIC;
            rem_nxt   = rem_dec;
            if (rem_dec == 16'd0) begin
              verd_v  = 1'b1;
              verd_st = ST_OK;
            end
          end
          default: begin
            verd_v  = 1'b1;
            verd_st = ST_TRUNCATED;
          end
        endcase
      end
    end
    verdict_sent_nxt = verdict_sent_r | verd_v;
    // End of marker: close with truncation if still open, then rearm
    if (end_of_marker) begin
      if (!verdict_sent_nxt) begin
        verd_v  = 1'b1;
        verd_st = ST_TRUNCATED;
      end
      phase_nxt        = PH_HEADER;
      pos_nxt          = 16'd0;
      len_nxt          = 16'd0;
      rem_nxt          = 16'd0;
      size_hi_nxt      = 8'd0;
      verdict_sent_nxt = 1'b0;
    end
  end

  // Pack results in order: data byte first, verdict after it
  always_comb begin
    data_res = '{item_kind: data_kind, out_byte: data_byte, status: ST_OK, last_result: 1'b0};
    verd_res = '{item_kind: KIND_VERDICT, out_byte: 8'd0, status: verd_st, last_result: 1'b1};
    push.first  = data_v ? data_res : verd_res;
    push.second = verd_res;
    push.count  = in_fire ? ({1'b0, data_v} + {1'b0, verd_v}) : 2'd0;
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      pos_r          <= 16'd0;
      len_r          <= 16'd0;
      rem_r          <= 16'd0;
      size_hi_r      <= 8'd0;
      verdict_sent_r <= 1'b0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      pos_r          <= pos_nxt;
      len_r          <= len_nxt;
      rem_r          <= rem_nxt;
      size_hi_r      <= size_hi_nxt;
      verdict_sent_r <= verdict_sent_nxt;
    end
  end

endmodule

// ----- rtl/hgmp_out_queue.sv -----
// Result queue that takes up to two results per cycle and delivers one unless the output stalls.
// Depends on hgmp_pkg and the assertion macros header.
`include "hdr_gainmap_metadata_parser_core_macros.svh"

module hgmp_out_queue
  import hgmp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room_two,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr_p1, wr_ptr_p2;
  logic               pop;

  assign wr_ptr_p1 = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign wr_ptr_p2 = (wr_ptr_p1 == PTR_LAST) ? '0 : wr_ptr_p1 + 1'b1;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room_two  = (count_r <= CNT_W'(DEPTH - 2));

  // Update pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = wr_ptr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ((rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r]  <= push.first;
    if (push.count == 2'd2) mem_r[wr_ptr_p1] <= push.second;
  end

  `HGMP_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "queue overfilled")
  `HGMP_ASSERT_ALWAYS(a_push_room, push.count == 2'd0 || room_two, "push without room")
  `HGMP_ASSERT_NEXT(a_empty_holds, count_r == '0 && push.count == 2'd0, count_r == '0,
                    "empty queue gained an entry without a push")

endmodule

// ----- rtl/hdr_gainmap_metadata_parser_core.sv -----
// Top level of the gain-map HDR metadata parser for one APP8 marker payload.
// Depends on hgmp_pkg, hgmp_parser and hgmp_out_queue.

// The block takes one payload byte per clock while not stalled and answers
// each byte within the same transfer cycle into a small result queue: static
// bytes come out as kind 0, dynamic bytes as kind 1, and every marker ends
// with exactly one verdict (kind 2, last_result set). A byte yields at most
// one result, except the last dynamic data byte, or a data byte that also
// ends the marker early, which yields the data byte and the verdict.
// The input stalls while the result queue has fewer than two free entries, so
// with the output draining every cycle the block sustains one byte per cycle;
// the queue's single read port sets the output at one result per cycle.
module hdr_gainmap_metadata_parser_core
  import hgmp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_payload_length,
  input  logic        in_end_of_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_out_byte,
  output logic [2:0]  out_status,
  output logic        out_last_result
);

  push_t   push;
  logic    room_two;
  logic    in_fire;
  result_t out_res;

  // Accept a byte only when two result slots are free
  assign in_stall = !room_two;
  assign in_fire  = in_valid && room_two;

  hgmp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .data_byte      (in_data_byte),
    .payload_length (in_payload_length),
    .end_of_marker  (in_end_of_marker),
    .push           (push)
  );

  hgmp_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_item_kind   = out_res.item_kind;
  assign out_out_byte    = out_res.out_byte;
  assign out_status      = out_res.status;
  assign out_last_result = out_res.last_result;

endmodule
